### rtl/core/ibc_pkg.sv
// ibc_pkg: shared types, widths and register codes for the isometric
// bounding-box centering block. No dependencies.
package ibc_pkg;

  localparam int COORD_W    = 10;
  localparam int ELEV_W     = 16;
  localparam int ANGLE_W    = 16;
  localparam int SCALE_W    = 32;
  localparam int WIN_W      = 12;
  localparam int PX_W       = 12;
  localparam int PY_W       = 24;
  localparam int Q17_W      = 60;
  localparam int OFS_W      = 40;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  localparam int unsigned MAX_DIM_DEF = 1024;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_COS_ANGLE     = 3'd0,
    CFG_SIN_ANGLE     = 3'd1,
    CFG_HEIGHT_GAIN   = 3'd2,
    CFG_SCALE_FACTOR  = 3'd3,
    CFG_WINDOW_WIDTH  = 3'd4,
    CFG_WINDOW_HEIGHT = 3'd5
  } cfg_reg_t;

  typedef struct packed {
    logic        [COORD_W-1:0] col_index;
    logic        [COORD_W-1:0] row_index;
    logic signed [ELEV_W-1:0]  elevation;
    logic                      last_point;
  } ibc_in_t;

  typedef struct packed {
    logic signed [OFS_W-1:0] offset_x;
    logic signed [OFS_W-1:0] offset_y;
  } ibc_out_t;

  typedef struct packed {
    logic signed [ANGLE_W-1:0] cos_angle;
    logic signed [ANGLE_W-1:0] sin_angle;
    logic signed [ANGLE_W-1:0] height_gain;
    logic        [SCALE_W-1:0] scale_factor;
    logic        [WIN_W-1:0]   window_width;
    logic        [WIN_W-1:0]   window_height;
  } ibc_cfg_t;

  typedef struct packed {
    logic signed [PX_W-1:0] px;
    logic signed [PY_W-1:0] py;
    logic                   last;
  } ibc_proj_t;

  typedef struct packed {
    logic signed [PX_W-1:0] lo_x;
    logic signed [PX_W-1:0] hi_x;
    logic signed [PY_W-1:0] lo_y;
    logic signed [PY_W-1:0] hi_y;
  } ibc_ext_t;

  localparam ibc_cfg_t CFG_RESET = '{
    cos_angle:     16'sd14189,
    sin_angle:     16'sd8192,
    height_gain:   16'sd256,
    scale_factor:  32'd65536,
    window_width:  12'd1920,
    window_height: 12'd1080
  };

endpackage

### rtl/core/ibc_project.sv
// ibc_project: input register, coordinate clamp and isometric projection
// into a registered (px, py) beat. Depends on ibc_pkg.
module ibc_project #(
  parameter int unsigned MAX_DIM = ibc_pkg::MAX_DIM_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  ibc_pkg::ibc_in_t      in_data,
  input  ibc_pkg::ibc_cfg_t     cfg,
  output logic                  prj_valid,
  input  logic                  prj_ready,
  output ibc_pkg::ibc_proj_t    prj
);

  localparam int unsigned COORD_MAX = (1 << ibc_pkg::COORD_W) - 1;
  localparam int unsigned LIM = (MAX_DIM - 1 > COORD_MAX) ? COORD_MAX : MAX_DIM - 1;
  localparam logic [ibc_pkg::COORD_W-1:0] COORD_LIM = ibc_pkg::COORD_W'(LIM);

  logic               s1_v_r;
  ibc_pkg::ibc_in_t   s1_r;
  ibc_pkg::ibc_in_t   s1_nxt;
  logic               prj_v_r;
  ibc_pkg::ibc_proj_t prj_r;
  ibc_pkg::ibc_proj_t prj_nxt;
  logic               s1_free;
  logic               prj_free;

  logic signed [ibc_pkg::COORD_W:0]   dx;
  logic        [ibc_pkg::COORD_W:0]   sxy;
  logic signed [26:0]                 prod_x;
  logic signed [26:0]                 rnd_x;
  logic signed [27:0]                 prod_s;
  logic signed [31:0]                 prod_g;
  logic signed [37:0]                 sum_y;
  logic signed [37:0]                 rnd_y;

  // clamp coordinates on the way in
  always_comb begin
    s1_nxt = in_data;
    if (in_data.col_index > COORD_LIM) s1_nxt.col_index = COORD_LIM;
    if (in_data.row_index > COORD_LIM) s1_nxt.row_index = COORD_LIM;
  end

  // px = trunc((x - y) * cos / 2^14), py = trunc(((x + y) * sin - z * gain * 64) / 2^14)
  always_comb begin
    dx     = $signed({1'b0, s1_r.col_index}) - $signed({1'b0, s1_r.row_index});
    sxy    = {1'b0, s1_r.col_index} + {1'b0, s1_r.row_index};
    prod_x = dx * cfg.cos_angle;
    rnd_x  = prod_x + (prod_x[26] ? 27'sd16383 : 27'sd0);
    prod_s = $signed({1'b0, sxy}) * cfg.sin_angle;
    prod_g = s1_r.elevation * cfg.height_gain;
    sum_y  = 38'(prod_s) - (38'(prod_g) <<< 6);
    rnd_y  = sum_y + (sum_y[37] ? 38'sd16383 : 38'sd0);
    prj_nxt.px   = rnd_x[25:14];
    prj_nxt.py   = rnd_y[37:14];
    prj_nxt.last = s1_r.last_point;
  end

  assign prj_free = !prj_v_r || prj_ready;
  assign s1_free  = !s1_v_r || prj_free;
  assign in_ready = s1_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      prj_v_r <= 1'b0;
    end else begin
      if (s1_free)  s1_v_r  <= in_valid;
      if (prj_free) prj_v_r <= s1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && s1_free) s1_r  <= s1_nxt;
    if (s1_v_r && prj_free)  prj_r <= prj_nxt;
  end

  assign prj_valid = prj_v_r;
  assign prj       = prj_r;

endmodule

### rtl/core/ibc_extent.sv
// ibc_extent: running min/max of the projected points over a frame; hands
// the final box to the offset stage on the last point. Depends on ibc_pkg.
module ibc_extent (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               prj_valid,
  output logic               prj_ready,
  input  ibc_pkg::ibc_proj_t prj,
  output logic               ext_valid,
  input  logic               ext_ready,
  output ibc_pkg::ibc_ext_t  ext
);

  logic              started_r;
  ibc_pkg::ibc_ext_t box_r;
  ibc_pkg::ibc_ext_t box_nxt;
  logic              ext_v_r;
  ibc_pkg::ibc_ext_t ext_r;
  logic              ext_free;
  logic              take;

  always_comb begin
    box_nxt = box_r;
    if (!started_r || prj.px < box_r.lo_x) box_nxt.lo_x = prj.px;
    if (!started_r || prj.px > box_r.hi_x) box_nxt.hi_x = prj.px;
    if (!started_r || prj.py < box_r.lo_y) box_nxt.lo_y = prj.py;
    if (!started_r || prj.py > box_r.hi_y) box_nxt.hi_y = prj.py;
  end

  assign ext_free  = !ext_v_r || ext_ready;
  assign prj_ready = !prj.last || ext_free;
  assign take      = prj_valid && prj_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      started_r <= 1'b0;
      ext_v_r   <= 1'b0;
    end else begin
      if (take)     started_r <= !prj.last;
      if (ext_free) ext_v_r   <= take && prj.last;
    end
  end

  always_ff @(posedge clk) begin
    if (take)             box_r <= box_nxt;
    if (take && prj.last) ext_r <= box_nxt;
  end

  assign ext_valid = ext_v_r;
  assign ext       = ext_r;

  a_rearm: assert property (@(posedge clk) disable iff (!rst_n)
    take && prj.last |=> !started_r && ext_v_r)
    else $error("frame did not rearm on last point");

  a_box_order: assert property (@(posedge clk) disable iff (!rst_n)
    ext_v_r |-> (ext_r.lo_x <= ext_r.hi_x) && (ext_r.lo_y <= ext_r.hi_y))
    else $error("bounding box min above max");

  a_hold_box: assert property (@(posedge clk) disable iff (!rst_n)
    ext_v_r && !ext_ready |=> ext_v_r && $stable(ext_r))
    else $error("stalled box changed");

endmodule

### rtl/core/ibc_offset.sv
// ibc_offset: centering offsets from the frame box, a multiply stage then
// a combine, truncate and saturate stage into the result register. Depends on ibc_pkg.
module ibc_offset (
  input  logic              clk,
  input  logic              rst_n,
  input  ibc_pkg::ibc_cfg_t cfg,
  input  logic              ext_valid,
  output logic              ext_ready,
  input  ibc_pkg::ibc_ext_t ext,
  output logic              out_valid,
  input  logic              out_ready,
  output ibc_pkg::ibc_out_t out_data
);

  localparam int QW = ibc_pkg::Q17_W;
  localparam int OW = ibc_pkg::OFS_W;
  localparam int SW = ibc_pkg::SCALE_W;
  localparam int XW = ibc_pkg::PX_W;
  localparam int YW = ibc_pkg::PY_W;

  logic signed [SW:0]      sc;
  logic signed [XW:0]      span_x;
  logic signed [YW:0]      span_y;
  logic signed [XW+SW+1:0] dprod_x_r;
  logic signed [XW+SW:0]   lprod_x_r;
  logic signed [YW+SW+1:0] dprod_y_r;
  logic signed [YW+SW:0]   lprod_y_r;
  logic                    mul_v_r;
  logic                    out_v_r;
  ibc_pkg::ibc_out_t       out_r;
  ibc_pkg::ibc_out_t       out_nxt;
  logic signed [QW-1:0]    q17_x;
  logic signed [QW-1:0]    q17_y;
  logic                    mul_free;
  logic                    out_free;

  // Q.17 -> Q.8 with truncation toward zero, then clip to the output range
  function automatic logic signed [OW-1:0] to_q8(input logic signed [QW-1:0] q17);
    logic signed [QW-1:0] r;
    logic signed [QW-10:0] q;
    r = q17 + (q17[QW-1] ? QW'(511) : QW'(0));
    q = r[QW-1:9];
    if (q[QW-10:OW-1] == {(QW-8-OW){q[OW-1]}}) return q[OW-1:0];
    else if (q[QW-10]) return {1'b1, {(OW-1){1'b0}}};
    else return {1'b0, {(OW-1){1'b1}}};
  endfunction

  assign sc     = $signed({1'b0, cfg.scale_factor});
  assign span_x = ext.hi_x - ext.lo_x;
  assign span_y = ext.hi_y - ext.lo_y;

  always_comb begin
    q17_x = $signed({{(QW-ibc_pkg::WIN_W-16){1'b0}}, cfg.window_width, 16'b0})
            - QW'(dprod_x_r) - (QW'(lprod_x_r) <<< 1);
    q17_y = $signed({{(QW-ibc_pkg::WIN_W-16){1'b0}}, cfg.window_height, 16'b0})
            - QW'(dprod_y_r) - (QW'(lprod_y_r) <<< 1);
    out_nxt.offset_x = to_q8(q17_x);
    out_nxt.offset_y = to_q8(q17_y);
  end

  assign out_free  = !out_v_r || out_ready;
  assign mul_free  = !mul_v_r || out_free;
  assign ext_ready = mul_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mul_v_r <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      if (mul_free) mul_v_r <= ext_valid;
      if (out_free) out_v_r <= mul_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (ext_valid && mul_free) begin
      dprod_x_r <= span_x * sc;
      lprod_x_r <= ext.lo_x * sc;
      dprod_y_r <= span_y * sc;
      lprod_y_r <= ext.lo_y * sc;
    end
    if (mul_v_r && out_free) out_r <= out_nxt;
  end

  assign out_valid = out_v_r;
  assign out_data  = out_r;

  a_no_drop: assert property (@(posedge clk) disable iff (!rst_n)
    mul_v_r && !out_free |=> mul_v_r && $stable(dprod_y_r))
    else $error("product stage lost a beat under stall");

  a_advance: assert property (@(posedge clk) disable iff (!rst_n)
    mul_v_r && out_free |=> out_v_r)
    else $error("product stage did not reach result register");

  a_accept: assert property (@(posedge clk) disable iff (!rst_n)
    ext_valid && ext_ready |=> mul_v_r)
    else $error("box beat not captured");

endmodule

### rtl/core/isometric_bbox_centering.sv
// isometric_bbox_centering: top level; configuration registers, projection,
// frame extent and offset stages. Depends on ibc_pkg, ibc_project, ibc_extent, ibc_offset.
//
//   channel  dir  handshake              payload
//   in_      in   in_valid / in_ready    ibc_in_t: col, row, elevation, last flag
//   out_     out  out_valid / out_ready  ibc_out_t: offset_x, offset_y (Q.8)
//   cfg_     in   cfg_valid / cfg_ready  cfg_index (3 bits), cfg_data (32 bits)
//
// one point per cycle while in_ready is high; a frame result follows its last point down the stages below
// pipeline: input register, projection register, extent box, products, result register
// reset (synchronous, active low) clears stage valids, frame state and the config registers
// a stalled result blocks input only once three results wait and a further last point
// reaches the extent stage; points that are not last keep flowing
// cfg_ready is always high; unknown indexes are ignored
module isometric_bbox_centering #(
  parameter int unsigned MAX_DIM = ibc_pkg::MAX_DIM_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  ibc_pkg::ibc_in_t                  in_data,
  output logic                              out_valid,
  input  logic                              out_ready,
  output ibc_pkg::ibc_out_t                 out_data,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [ibc_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [ibc_pkg::CFG_DATA_W-1:0]    cfg_data
);

  ibc_pkg::ibc_cfg_t  cfg_r;
  ibc_pkg::ibc_cfg_t  cfg_nxt;
  logic               prj_valid;
  logic               prj_ready;
  ibc_pkg::ibc_proj_t prj;
  logic               ext_valid;
  logic               ext_ready;
  ibc_pkg::ibc_ext_t  ext;

  assign cfg_ready = 1'b1;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      case (cfg_index)
        ibc_pkg::CFG_COS_ANGLE:     cfg_nxt.cos_angle     = cfg_data[15:0];
        ibc_pkg::CFG_SIN_ANGLE:     cfg_nxt.sin_angle     = cfg_data[15:0];
        ibc_pkg::CFG_HEIGHT_GAIN:   cfg_nxt.height_gain   = cfg_data[15:0];
        ibc_pkg::CFG_SCALE_FACTOR:  cfg_nxt.scale_factor  = cfg_data;
        ibc_pkg::CFG_WINDOW_WIDTH:  cfg_nxt.window_width  = cfg_data[11:0];
        ibc_pkg::CFG_WINDOW_HEIGHT: cfg_nxt.window_height = cfg_data[11:0];
        default: cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= ibc_pkg::CFG_RESET;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  ibc_project #(
    .MAX_DIM (MAX_DIM)
  ) u_project (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .cfg       (cfg_r),
    .prj_valid (prj_valid),
    .prj_ready (prj_ready),
    .prj       (prj)
  );

  ibc_extent u_extent (
    .clk       (clk),
    .rst_n     (rst_n),
    .prj_valid (prj_valid),
    .prj_ready (prj_ready),
    .prj       (prj),
    .ext_valid (ext_valid),
    .ext_ready (ext_ready),
    .ext       (ext)
  );

  ibc_offset u_offset (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .ext_valid (ext_valid),
    .ext_ready (ext_ready),
    .ext       (ext),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

### verif/ibc_offset_check_pkg.sv
// ibc_offset_check_pkg: scoreboard for the isometric bounding-box centering block;
// tracks register settings and the frame extent, predicts centering offsets.
// Depends on ibc_pkg.
package ibc_offset_check_pkg;
  import ibc_pkg::*;

  localparam longint Q14_ONE    = 16384;
  localparam longint GAIN_ALIGN = 64;
  localparam longint Q17_TO_Q8  = 512;
  localparam longint OFS_TOP    = (longint'(1) <<< (OFS_W - 1)) - 1;

  class centering_scoreboard;
    ibc_cfg_t regs;
    int       lo_x, hi_x, lo_y, hi_y;
    bit       started;
    ibc_out_t offsets_due[$];
    int       errors;

    function new();
      regs    = CFG_RESET;
      lo_x    = 0;
      hi_x    = 0;
      lo_y    = 0;
      hi_y    = 0;
      started = 1'b0;
      errors  = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        CFG_COS_ANGLE:     regs.cos_angle     = data[ANGLE_W-1:0];
        CFG_SIN_ANGLE:     regs.sin_angle     = data[ANGLE_W-1:0];
        CFG_HEIGHT_GAIN:   regs.height_gain   = data[ANGLE_W-1:0];
        CFG_SCALE_FACTOR:  regs.scale_factor  = data[SCALE_W-1:0];
        CFG_WINDOW_WIDTH:  regs.window_width  = data[WIN_W-1:0];
        CFG_WINDOW_HEIGHT: regs.window_height = data[WIN_W-1:0];
        default: ;
      endcase
    endfunction

    // shift in q.17, then truncated to q.8 and clamped to the output range
    function longint centre(longint window, longint lo, longint hi);
      longint s, q17, q8;
      s   = longint'(regs.scale_factor);
      q17 = (window <<< 16) - (hi - lo) * s - 2 * lo * s;
      q8  = q17 / Q17_TO_Q8;
      if (q8 > OFS_TOP) q8 = OFS_TOP;
      if (q8 < -OFS_TOP - 1) q8 = -OFS_TOP - 1;
      return q8;
    endfunction

    function void take_point(ibc_in_t p);
      longint   x, y, z;
      int       px, py;
      ibc_out_t res;
      x = longint'(p.col_index);
      y = longint'(p.row_index);
      z = longint'(signed'(p.elevation));
      if (x > longint'(MAX_DIM_DEF) - 1) x = longint'(MAX_DIM_DEF) - 1;
      if (y > longint'(MAX_DIM_DEF) - 1) y = longint'(MAX_DIM_DEF) - 1;
      px = int'(((x - y) * longint'(regs.cos_angle)) / Q14_ONE);
      py = int'(((x + y) * longint'(regs.sin_angle)
                 - z * longint'(regs.height_gain) * GAIN_ALIGN) / Q14_ONE);
      if (!started) begin
        lo_x    = px;
        hi_x    = px;
        lo_y    = py;
        hi_y    = py;
        started = 1'b1;
      end else begin
        if (px < lo_x) lo_x = px;
        if (px > hi_x) hi_x = px;
        if (py < lo_y) lo_y = py;
        if (py > hi_y) hi_y = py;
      end
      if (p.last_point) begin
        res.offset_x = OFS_W'(centre(longint'(regs.window_width), lo_x, hi_x));
        res.offset_y = OFS_W'(centre(longint'(regs.window_height), lo_y, hi_y));
        offsets_due.push_back(res);
        started = 1'b0;
      end
    endfunction

    function void check_offsets(ibc_out_t got, time stamp);
      ibc_out_t exp;
      if (offsets_due.size() == 0) begin
        $display("%0t: unexpected result beat offset_x %0d offset_y %0d",
                 stamp, got.offset_x, got.offset_y);
        errors++;
        return;
      end
      exp = offsets_due.pop_front();
      if (got.offset_x !== exp.offset_x) begin
        $display("%0t: offset_x expected %0d actual %0d", stamp, exp.offset_x, got.offset_x);
        errors++;
      end
      if (got.offset_y !== exp.offset_y) begin
        $display("%0t: offset_y expected %0d actual %0d", stamp, exp.offset_y, got.offset_y);
        errors++;
      end
    endfunction

    function int pending();
      return offsets_due.size();
    endfunction

    function void close_out(time stamp);
      ibc_out_t exp;
      while (offsets_due.size() != 0) begin
        exp = offsets_due.pop_front();
        $display("%0t: missing result, expected offset_x %0d offset_y %0d actual none",
                 stamp, exp.offset_x, exp.offset_y);
        errors++;
      end
    endfunction
  endclass

endpackage

### verif/isometric_bbox_centering_test.sv
// isometric_bbox_centering_test: drives points and register writes into the
// centering block and checks every offset beat. Depends on ibc_pkg and
// ibc_offset_check_pkg.
module isometric_bbox_centering_test;
  timeunit 1ns;
  timeprecision 1ps;

  import ibc_pkg::*;
  import ibc_offset_check_pkg::*;

  localparam logic [CFG_IDX_W-1:0] CFG_UNMAPPED_LO = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_UNMAPPED_HI = 3'd7;
  localparam int PHASES       = 8;
  localparam int PHASE_POINTS = 130;
  localparam int DRAIN_LIMIT  = 2000;
  localparam int SETTLE       = 10;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_ready;
  ibc_in_t               in_data;
  logic                  out_valid;
  logic                  out_ready;
  ibc_out_t              out_data;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  centering_scoreboard board = new();
  int hold_req;
  bit steady;

  isometric_bbox_centering uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #5 clk = ~clk;

  function automatic int pause_cycles();
    if ($urandom_range(9) == 0) return $urandom_range(40, 10);
    return $urandom_range(3, 1);
  endfunction

  function automatic ibc_in_t pt(int c, int r, int e, bit l);
    ibc_in_t p;
    p.col_index  = COORD_W'(c);
    p.row_index  = COORD_W'(r);
    p.elevation  = ELEV_W'(e);
    p.last_point = l;
    return p;
  endfunction

  function automatic logic [COORD_W-1:0] pick_coord();
    case ($urandom_range(7))
      0: return '0;
      1: return '1;
      default: return COORD_W'($urandom);
    endcase
  endfunction

  function automatic ibc_in_t random_point(bit last);
    ibc_in_t p;
    p.col_index = pick_coord();
    p.row_index = pick_coord();
    case ($urandom_range(7))
      0: p.elevation = {1'b1, {(ELEV_W-1){1'b0}}};
      1: p.elevation = {1'b0, {(ELEV_W-1){1'b1}}};
      2: p.elevation = ELEV_W'(int'($urandom_range(200)) - 100);
      default: p.elevation = ELEV_W'($urandom);
    endcase
    p.last_point = last;
    return p;
  endfunction

  task automatic idle_input(int n);
    repeat (n) begin
      @(negedge clk);
      in_valid = 1'b0;
    end
  endtask

  task automatic send_point(ibc_in_t p);
    @(negedge clk);
    in_valid = 1'b1;
    in_data  = p;
    do @(posedge clk); while (!in_ready);
    board.take_point(p);
    if (!steady && $urandom_range(3) == 0) idle_input(pause_cycles());
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = data;
    do @(posedge clk); while (!cfg_ready);
    board.write_reg(idx, data);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic program_regs(logic [CFG_DATA_W-1:0] c, logic [CFG_DATA_W-1:0] s,
                              logic [CFG_DATA_W-1:0] g, logic [CFG_DATA_W-1:0] sc,
                              logic [CFG_DATA_W-1:0] w, logic [CFG_DATA_W-1:0] h);
    write_reg(CFG_COS_ANGLE, c);
    write_reg(CFG_SIN_ANGLE, s);
    write_reg(CFG_HEIGHT_GAIN, g);
    write_reg(CFG_SCALE_FACTOR, sc);
    write_reg(CFG_WINDOW_WIDTH, w);
    write_reg(CFG_WINDOW_HEIGHT, h);
  endtask

  task automatic wait_drained();
    int n;
    n = 0;
    idle_input(1);
    while (board.pending() != 0 && n < DRAIN_LIMIT) begin
      @(posedge clk);
      n++;
    end
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic run_frames(int points);
    int sent, len;
    sent = 0;
    while (sent < points) begin
      len = ($urandom_range(9) == 0) ? $urandom_range(60, 10) : $urandom_range(6, 1);
      if ($urandom_range(7) == 0) steady = !steady;
      for (int i = 0; i < len; i++) send_point(random_point(i == len - 1));
      sent += len;
    end
    steady = 1'b0;
  endtask

  // receiver side: random ready, long hold on request
  initial begin
    int run;
    run       = 0;
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req > 0) begin
        out_ready = 1'b0;
        hold_req--;
      end else if (steady) begin
        out_ready = 1'b1;
      end else if (run > 0) begin
        run--;
      end else if ($urandom_range(3) == 0) begin
        out_ready = 1'b0;
        run = pause_cycles();
      end else begin
        out_ready = 1'b1;
        run = $urandom_range(8);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) board.check_offsets(out_data, $time);
  end

  initial begin
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_data   = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    hold_req  = 0;
    steady    = 1'b0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // corners at reset settings, single point frames included
    send_point(pt(0, 0, 0, 1));
    send_point(pt(1023, 1023, 32767, 1));
    send_point(pt(0, 1023, -32768, 1));
    send_point(pt(1023, 0, -32768, 0));
    send_point(pt(0, 1023, 32767, 0));
    send_point(pt(512, 511, -1, 0));
    send_point(pt(1, 2, 1, 1));
    send_point(pt(1023, 0, 0, 0));
    send_point(pt(1023, 0, 0, 1));
    send_point(pt(341, 682, -21846, 0));
    send_point(pt(682, 341, 21845, 1));
    wait_drained();

    // receiver blocked while short frames keep coming
    steady   = 1'b1;
    hold_req = 150;
    for (int i = 0; i < 20; i++) send_point(random_point($urandom_range(1) == 1));
    send_point(random_point(1'b1));
    steady = 1'b0;
    wait_drained();

    for (int k = 0; k < PHASES; k++) begin
      case (k)
        0: ;
        1: program_regs(32'(-16384), 32'd16384, 32'(-32768), 32'd0, 32'd1, 32'd4095);
        2: program_regs(32'd16384, 32'(-16384), 32'd32767, 32'hFFFF_FFFF, 32'd4095, 32'd1);
        3: begin
          write_reg(CFG_UNMAPPED_LO, $urandom);
          program_regs(32'(-32768), 32'd32767, 32'd0, 32'd1, 32'd0, 32'd0);
          write_reg(CFG_UNMAPPED_HI, $urandom);
        end
        default: program_regs({16'($urandom), 16'($urandom_range(32768) - 16384)},
                              {16'($urandom), 16'($urandom_range(32768) - 16384)},
                              $urandom,
                              ($urandom_range(3) == 0) ? $urandom : $urandom_range(32'h30000),
                              {20'($urandom), 12'($urandom_range(4095, 1))},
                              {20'($urandom), 12'($urandom_range(4095, 1))});
      endcase
      if (k == 2) begin
        // offsets past both ends of the output range
        send_point(pt(0, 1023, 32767, 1));
        send_point(pt(0, 0, -32768, 1));
      end
      run_frames(PHASE_POINTS);
      wait_drained();
    end

    board.close_out($time);
    if (board.errors == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("end of test: mismatches");
    $finish;
  end

endmodule
